[hdl/sha256h_pkg.sv]
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
// Depends on nothing. Every other file refers to it by scoped names.
`default_nettype none

package sha256h_pkg;

   // One input item: a data byte or a finish command.
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   // One result item: a digest word and its position.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Source of the byte pushed into the block buffer.
   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [5:0] FILL_LAST    = 6'd63;  // push that completes the block
   localparam logic [5:0] FILL_PRE_LEN = 6'd55;  // push that leaves room for the length
   localparam logic [5:0] ROUND_LAST   = 6'd63;
   localparam logic [2:0] WORD_LAST    = 3'd7;
   localparam logic [3:0] DIGEST_WORDS = 4'd8;

   // Controller to datapath.
   typedef struct packed {
      logic       push;       // shift one byte into the block buffer
      logic [1:0] byte_sel;
      logic       comp_init;  // load working variables from the chaining hash
      logic       round_en;   // run one compression round
      logic       hash_upd;   // fold working variables into the chaining hash
      logic       emit;       // move the digest to the output, restart the message
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
      logic       out_busy;
   } sts_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

[hdl/sha256h_ctrl.sv]
// Sequencer of the SHA-256 hasher: byte intake, padding, compression steps, digest emit.
// Depends on sha256h_pkg; drives sha256h_datapath through cmd_type, reads sts_type.
`default_nettype none

module sha256h_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output logic                      req_stall,
   output sha256h_pkg::cmd_type      cmd,
   input  wire sha256h_pkg::sts_type sts
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PADZ  = 3'd1;
   localparam logic [2:0] ST_PADL  = 3'd2;
   localparam logic [2:0] ST_INIT  = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_UPD   = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;    // finish in progress
   logic       tail_ff, tail_in;  // running compression holds the length
   logic       accept;

   // finish waits until the previous digest has drained
   assign req_stall = (state_ff != ST_IDLE) ||
                      (req_kind == sha256h_pkg::KIND_FINISH && sts.out_busy);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      fin_in   = fin_ff;
      tail_in  = tail_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.push = 1'b1;
               if (req_kind == sha256h_pkg::KIND_FINISH) begin
                  cmd.byte_sel = sha256h_pkg::BSEL_PAD;
                  fin_in       = 1'b1;
                  priority if (sts.fill == sha256h_pkg::FILL_LAST) state_in = ST_INIT;
                  else if (sts.fill == sha256h_pkg::FILL_PRE_LEN)  state_in = ST_PADL;
                  else                                              state_in = ST_PADZ;
               end else begin
                  cmd.byte_sel = sha256h_pkg::BSEL_DATA;
                  if (sts.fill == sha256h_pkg::FILL_LAST) state_in = ST_INIT;
               end
            end
         end
         ST_PADZ: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = sha256h_pkg::BSEL_ZERO;
            priority if (sts.fill == sha256h_pkg::FILL_LAST) state_in = ST_INIT;
            else if (sts.fill == sha256h_pkg::FILL_PRE_LEN)  state_in = ST_PADL;
            else                                              state_in = ST_PADZ;
         end
         ST_PADL: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = sha256h_pkg::BSEL_LEN;
            if (sts.fill == sha256h_pkg::FILL_LAST) begin
               tail_in  = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.comp_init = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (sts.round_last) state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.hash_upd = 1'b1;
            priority if (tail_ff) state_in = ST_EMIT;
            else if (fin_ff)      state_in = ST_PADZ;
            else                  state_in = ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            fin_in   = 1'b0;
            tail_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            fin_in   = 1'b0;
            tail_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

`default_nettype wire

[hdl/sha256h_datapath.sv]
// Datapath of the SHA-256 hasher: block shift line, message schedule, round logic,
// chaining hash, bit count and the digest output register. Depends on sha256h_pkg.
`default_nettype none

module sha256h_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sha256h_pkg::cmd_type cmd,
   output sha256h_pkg::sts_type      sts,
   input  wire logic [7:0]           in_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output sha256h_pkg::rsp_type      rsp_data
);

   // Block buffer and schedule window share one shift line; word 0 sits in the top bits.
   logic [511:0] blk_ff, blk_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic [31:0]  wk_ff [8];
   logic [31:0]  wk_in [8];
   logic [31:0]  hash_ff [8];
   logic [31:0]  hash_in [8];
   logic [31:0]  dig_ff [8];
   logic [31:0]  dig_in [8];
   logic [2:0]   idx_ff, idx_in;
   logic [3:0]   left_ff, left_in;

   logic [7:0]   push_byte;
   logic [31:0]  w_cur, w_new, t1, t2, ch, maj;
   logic         rsp_take;

   always_comb begin
      unique case (cmd.byte_sel)
         sha256h_pkg::BSEL_DATA: push_byte = in_byte;
         sha256h_pkg::BSEL_PAD:  push_byte = sha256h_pkg::PAD_BYTE;
         sha256h_pkg::BSEL_ZERO: push_byte = 8'h00;
         sha256h_pkg::BSEL_LEN:  push_byte = bits_ff[63:56];
         default:                push_byte = 8'h00;
      endcase
   end

   // schedule taps: W[t-16], W[t-15], W[t-7], W[t-2]
   assign w_cur = blk_ff[511:480];
   assign w_new = w_cur + sha256h_pkg::small_sigma0(blk_ff[479:448]) + blk_ff[223:192]
                  + sha256h_pkg::small_sigma1(blk_ff[63:32]);

   assign ch  = (wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]);
   assign maj = (wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
   assign t1  = wk_ff[7] + sha256h_pkg::big_sigma1(wk_ff[4]) + ch
                + sha256h_pkg::ROUND_K[rnd_ff] + w_cur;
   assign t2  = sha256h_pkg::big_sigma0(wk_ff[0]) + maj;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      blk_in  = blk_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      rnd_in  = rnd_ff;
      idx_in  = idx_ff;
      left_in = left_ff;
      for (int i = 0; i < 8; i++) begin
         wk_in[i]   = wk_ff[i];
         hash_in[i] = hash_ff[i];
         dig_in[i]  = dig_ff[i];
      end

      if (cmd.push) begin
         blk_in  = {blk_ff[503:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (cmd.byte_sel == sha256h_pkg::BSEL_DATA) bits_in = bits_ff + 64'd8;
         if (cmd.byte_sel == sha256h_pkg::BSEL_LEN)  bits_in = {bits_ff[55:0], 8'h00};
      end

      if (cmd.comp_init) begin
         rnd_in = '0;
         for (int i = 0; i < 8; i++) wk_in[i] = hash_ff[i];
      end

      if (cmd.round_en) begin
         blk_in   = {blk_ff[479:0], w_new};
         rnd_in   = rnd_ff + 6'd1;
         wk_in[7] = wk_ff[6];
         wk_in[6] = wk_ff[5];
         wk_in[5] = wk_ff[4];
         wk_in[4] = wk_ff[3] + t1;
         wk_in[3] = wk_ff[2];
         wk_in[2] = wk_ff[1];
         wk_in[1] = wk_ff[0];
         wk_in[0] = t1 + t2;
      end

      if (cmd.hash_upd) begin
         for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + wk_ff[i];
      end

      // emit only happens with the output drained, so it never meets a take
      if (cmd.emit) begin
         for (int i = 0; i < 8; i++) begin
            dig_in[i]  = hash_ff[i];
            hash_in[i] = sha256h_pkg::INIT_HASH[i];
         end
         idx_in  = '0;
         left_in = sha256h_pkg::DIGEST_WORDS;
      end else if (rsp_take) begin
         for (int i = 0; i < 7; i++) dig_in[i] = dig_ff[i + 1];
         idx_in  = idx_ff + 3'd1;
         left_in = left_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
         left_ff <= '0;
         idx_ff  <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha256h_pkg::INIT_HASH[i];
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         left_ff <= left_in;
         idx_ff  <= idx_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rnd_ff <= rnd_in;
      wk_ff  <= wk_in;
      dig_ff <= dig_in;
   end

   assign sts.fill       = fill_ff;
   assign sts.round_last = (rnd_ff == sha256h_pkg::ROUND_LAST);
   assign sts.out_busy   = (left_ff != 4'd0);

   assign rsp_valid            = sts.out_busy;
   assign rsp_data.digest_word = dig_ff[0];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == sha256h_pkg::WORD_LAST);

endmodule

`default_nettype wire

[hdl/sha256_byte_stream_hasher_top.sv]
// SHA-256 byte stream hasher: a data byte is shifted in when taken; the 64th byte of a block adds a
// compression (load, 64 rounds at one per cycle, hash update) before the next item is taken.
// A finish item pushes padding one byte per cycle (up to 72), runs one or two compressions,
// then puts 8 digest words out, one per cycle when not stalled.
// Synchronous active-high reset restores the initial hash, zero count and empty output.
`default_nettype none

module sha256_byte_stream_hasher_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire sha256h_pkg::req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output sha256h_pkg::rsp_type      rsp_data
);

   // Controller and datapath talk only through these two structs.
   sha256h_pkg::cmd_type cmd;
   sha256h_pkg::sts_type sts;

   // The controller accepts items in its idle state only. Data bytes may come in while
   // the previous digest still drains from the output register; a finish item waits
   // until the last digest word has been taken.
   sha256h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: the 512-bit shift line takes bytes, then doubles as the 16-word
   // schedule window during the rounds. The digest is copied into its own output
   // register so the chaining hash restarts at once for the next message.
   sha256h_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_byte   (req_data.data_byte),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/sha256h_checker.sv]
// Port-level checks of the SHA-256 hasher, bound to the top level.
// Depends on sha256h_pkg and sha256_byte_stream_hasher_top.
`default_nettype none

module sha256h_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire sha256h_pkg::req_type req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire sha256h_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_word == (rsp_data.word_index == sha256h_pkg::WORD_LAST))
      else $error("last_word does not match word_index");

   a_word_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         rsp_valid && rsp_data.word_index == 3'($past(rsp_data.word_index) + 3'd1))
      else $error("digest words not back to back in order");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == sha256h_pkg::KIND_FINISH |-> !rsp_valid)
      else $error("finish taken while a digest is still draining");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sha256_byte_stream_hasher_top sha256h_checker u_sha256h_checker (.*);

`default_nettype wire
